[hdl/crlf_line_assembler_echo_unit_macros.svh]
// assertion macros for the crlf line assembler echo unit
// expects signals clk and rst_n in the scope where a macro is used
`ifndef CRLF_LINE_ASSEMBLER_ECHO_UNIT_MACROS_SVH
`define CRLF_LINE_ASSEMBLER_ECHO_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// property checked outside reset
`define CLAE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// property checked on every edge, reset included
`define CLAE_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CLAE_ASSERT(lbl, prop, msg)
`define CLAE_ASSERT_RST(lbl, prop, msg)
`endif
`endif

[hdl/clae_pkg.sv]
// shared types, character codes and register indexes of the line assembler
// no dependencies
package clae_pkg;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [3:0] PREFIX_MAX = 4'd8;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_PREFIX_LEN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PREFIX_BYTES = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ECHO_RD,
    ST_ECHO_WAIT
  } state_t;

  // prefix settings and reload request from the register block
  typedef struct packed {
    logic        load;
    logic [3:0]  plen;
    logic [63:0] pbytes;
  } cfg_t;

  // prefix length clipped to the number of prefix bytes
  function automatic logic [3:0] eff_prefix(input logic [3:0] plen);
    eff_prefix = (plen > PREFIX_MAX) ? PREFIX_MAX : plen;
  endfunction

endpackage

[hdl/clae_ram.sv]
// generic single write port ram with registered read
// no dependencies
module clae_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/clae_ctrl.sv]
// sequencer of the line assembler: byte intake, prefix reload and echo walk
// depends on clae_pkg, clae_ram and the assertion macro header
`include "crlf_line_assembler_echo_unit_macros.svh"

module clae_ctrl
  import clae_pkg::*;
#(
  parameter int unsigned LINE_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  output logic       idle,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_echo_byte,
  output logic       out_last_byte
);

  localparam int unsigned AW = $clog2(LINE_DEPTH);

  state_t              state_r, state_nxt;
  logic [AW-1:0]       count_r, count_nxt;
  logic                cr_r, cr_nxt;
  logic [LINE_DEPTH-1:0] vld_r, vld_nxt;
  logic [2:0]          load_idx_r, load_idx_nxt;
  logic [AW-1:0]       echo_idx_r, echo_idx_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_byte_r, out_byte_nxt;
  logic                out_last_r, out_last_nxt;

  logic [3:0]    eff;
  logic          we, re, out_load, echo_last;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata, rdata;
  logic [AW:0]   count_inc;

  assign eff       = eff_prefix(cfg.plen);
  assign count_inc = {1'b0, count_r} + (AW+1)'(1);
  assign echo_last = (echo_idx_r == count_r);

  // line store
  clae_ram #(
    .WIDTH (8),
    .DEPTH (LINE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (echo_idx_r),
    .rdata (rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cr_r        <= 1'b0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cr_r        <= cr_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    load_idx_r <= load_idx_nxt;
    echo_idx_r <= echo_idx_nxt;
    rd_vld_r   <= rd_vld_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  // next state and datapath control
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    cr_nxt       = cr_r;
    load_idx_nxt = load_idx_r;
    echo_idx_nxt = echo_idx_r;
    rd_vld_nxt   = rd_vld_r;
    out_byte_nxt = out_byte_r;
    out_last_nxt = out_last_r;
    we           = 1'b0;
    re           = 1'b0;
    waddr        = count_r;
    wdata        = in_rx_byte;
    in_ready     = 1'b0;
    out_load     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (cfg.load) begin
          // reload prefix after a register write
          load_idx_nxt = '0;
          if (eff == 4'd0) begin
            count_nxt = '0;
            cr_nxt    = 1'b0;
          end else begin
            state_nxt = ST_LOAD;
          end
        end else begin
          in_ready = 1'b1;
          if (in_valid) begin
            if (!cr_r) begin
              if (in_rx_byte == CHAR_CR) begin
                cr_nxt = 1'b1;
              end else begin
                we = 1'b1;
                count_nxt = (count_inc == (AW+1)'(LINE_DEPTH)) ? '0 : count_inc[AW-1:0];
              end
            end else if (in_rx_byte != CHAR_LF) begin
              // discard the line
              count_nxt = '0;
              cr_nxt    = 1'b0;
            end else begin
              // terminate the line and start the echo walk
              we           = 1'b1;
              wdata        = CHAR_CR;
              echo_idx_nxt = '0;
              state_nxt    = ST_ECHO_RD;
            end
          end
        end
      end
      ST_LOAD: begin
        we    = 1'b1;
        waddr = AW'(load_idx_r);
        wdata = cfg.pbytes[{load_idx_r, 3'b000} +: 8];
        if ({1'b0, load_idx_r} == eff - 4'd1) begin
          count_nxt = AW'(eff);
          cr_nxt    = 1'b0;
          state_nxt = ST_IDLE;
        end else begin
          load_idx_nxt = load_idx_r + 3'd1;
        end
      end
      ST_ECHO_RD: begin
        re         = 1'b1;
        rd_vld_nxt = vld_r[echo_idx_r];
        state_nxt  = ST_ECHO_WAIT;
      end
      ST_ECHO_WAIT: begin
        out_load = !out_valid_r || out_ready;
        if (out_load) begin
          out_byte_nxt = rd_vld_r ? rdata : 8'h00;
          out_last_nxt = echo_last;
          if (echo_last) begin
            count_nxt = AW'(eff);
            cr_nxt    = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            echo_idx_nxt = echo_idx_r + AW'(1);
            state_nxt    = ST_ECHO_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // per-entry written flags, unwritten entries read as zero
  always_comb begin
    vld_nxt = vld_r;
    if (we) begin
      vld_nxt[waddr] = 1'b1;
    end
  end

  // output register
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign idle          = (state_r == ST_IDLE) && !cfg.load;
  assign out_valid     = out_valid_r;
  assign out_echo_byte = out_byte_r;
  assign out_last_byte = out_last_r;

  // checks
  `CLAE_ASSERT(a_echo_end, (state_r == ST_ECHO_WAIT && out_load && echo_last) |=> (state_r == ST_IDLE && count_r == AW'(eff)), "echo run did not end cleanly")
  `CLAE_ASSERT(a_echo_range, (state_r == ST_ECHO_RD || state_r == ST_ECHO_WAIT) |-> (echo_idx_r <= count_r), "echo index past line end")
  `CLAE_ASSERT(a_load_end, (state_r == ST_LOAD && {1'b0, load_idx_r} == eff - 4'd1) |=> (count_r == AW'(eff) && !cr_r), "prefix reload left bad count")
  `CLAE_ASSERT_RST(a_rst_out, !rst_n |=> !out_valid_r, "output valid after reset")

endmodule

[hdl/crlf_line_assembler_echo_unit.sv]
// crlf line assembler echo unit: stores line bytes, notes a CR and discards a line on CR without LF.
// a LF after CR ends a line of N = count+1 bytes, the last a CR written in place of the LF,
// and starts the echo walk: the read state reads an entry of the store ram, the wait state
// loads it into the output register, stalled while out_ready is low on a waiting byte.
// a register write holds off requests while the prefix (at most 8 bytes) is reloaded.
// synchronous active-low reset clears count, CR flag, output valid, entry flags, registers.
module crlf_line_assembler_echo_unit
  import clae_pkg::*;
#(
  parameter int unsigned LINE_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_rx_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_echo_byte,
  output logic                 out_last_byte
);

  logic [3:0]  plen_r;
  logic [63:0] pbytes_r;
  logic        load_r;
  logic        idle;
  logic        cfg_req;
  cfg_t        cfg;

  // no register write while a byte is offered
  assign cfg_ready = idle && !in_valid;
  assign cfg_req   = cfg_valid && cfg_ready;

  // configuration registers and reload request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r   <= '0;
      pbytes_r <= '0;
      load_r   <= 1'b0;
    end else begin
      load_r <= 1'b0;
      if (cfg_req) begin
        case (cfg_index)
          REG_PREFIX_LEN: begin
            plen_r <= cfg_data[3:0];
            load_r <= 1'b1;
          end
          REG_PREFIX_BYTES: begin
            pbytes_r <= cfg_data;
            load_r   <= 1'b1;
          end
          default: begin
            load_r <= 1'b0;
          end
        endcase
      end
    end
  end

  assign cfg.load   = load_r;
  assign cfg.plen   = plen_r;
  assign cfg.pbytes = pbytes_r;

  // sequencer with line store
  clae_ctrl #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .idle          (idle),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_echo_byte (out_echo_byte),
    .out_last_byte (out_last_byte)
  );

endmodule
